// ===== design/ftcal_pkg.sv =====
// shared types, constants and coefficient table of the force/torque calibration core
package ftcal_pkg;

   localparam int NUM_AXES         = 6;
   localparam int AXIS_W           = $clog2(NUM_AXES);
   localparam int GAUGE_W          = 16;
   localparam int VOLT_W           = 32;
   localparam int FORCE_W          = 32;
   localparam int VAZ_W            = 29;
   localparam int VPC_W            = 25;
   localparam int COEF_W           = 24;
   localparam int TARE_SUM_W       = 36;
   localparam int CSR_DATA_W       = 29;
   localparam int CSR_IDX_W        = 1;
   localparam int FIFO_DEPTH       = 2;
   localparam int FRAC_SHIFT       = 26;
   localparam int ADC_BITS_DEF     = 16;
   localparam int TARE_SAMPLES_DEF = 10;

   localparam logic signed [VAZ_W-1:0] VAZ_RESET = -29'sd167772160;
   localparam logic [VPC_W-1:0]        VPC_RESET = 25'd5120;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLT_AT_ZERO   = 1'b0,
      CSR_VOLT_PER_COUNT = 1'b1
   } csr_index_type;

   typedef logic signed [VOLT_W-1:0] volt_type;
   typedef volt_type [NUM_AXES-1:0]  volt_vec_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   // one converted frame on its way from front to back
   typedef struct packed {
      volt_vec_type volt;
      logic         is_tare;
      logic         is_last;
   } frame_entry_type;

   // calibration over gain in Q5.18, rounded half away from zero
   localparam longint COEF_SCALE = 64'sd2621440000;
   localparam longint G_FXY      = 64'sd22730008410;
   localparam longint G_FZ       = 64'sd11786833324;
   localparam longint G_TXY      = 64'sd3645857669;
   localparam longint G_TZ       = 64'sd3148403468;
   localparam longint G_FXY_H    = G_FXY / 2;
   localparam longint G_FZ_H     = G_FZ / 2;
   localparam longint G_TXY_H    = G_TXY / 2;
   localparam longint G_TZ_H     = G_TZ / 2;

   localparam coef_type COEF_ROM [NUM_AXES][NUM_AXES] = '{
      '{ 24'(( 64'sd6105    * COEF_SCALE + G_FXY_H) / G_FXY),
         24'((-64'sd19672   * COEF_SCALE - G_FXY_H) / G_FXY),
         24'((-64'sd179433  * COEF_SCALE - G_FXY_H) / G_FXY),
         24'(( 64'sd3770342 * COEF_SCALE + G_FXY_H) / G_FXY),
         24'(( 64'sd206223  * COEF_SCALE + G_FXY_H) / G_FXY),
         24'((-64'sd3752904 * COEF_SCALE - G_FXY_H) / G_FXY) },
      '{ 24'(( 64'sd202210  * COEF_SCALE + G_FXY_H) / G_FXY),
         24'((-64'sd4483887 * COEF_SCALE - G_FXY_H) / G_FXY),
         24'((-64'sd140611  * COEF_SCALE - G_FXY_H) / G_FXY),
         24'(( 64'sd2112528 * COEF_SCALE + G_FXY_H) / G_FXY),
         24'((-64'sd140373  * COEF_SCALE - G_FXY_H) / G_FXY),
         24'(( 64'sd2229920 * COEF_SCALE + G_FXY_H) / G_FXY) },
      '{ 24'((-64'sd2217321 * COEF_SCALE - G_FZ_H) / G_FZ),
         24'((-64'sd29397   * COEF_SCALE - G_FZ_H) / G_FZ),
         24'((-64'sd2209094 * COEF_SCALE - G_FZ_H) / G_FZ),
         24'((-64'sd75540   * COEF_SCALE - G_FZ_H) / G_FZ),
         24'((-64'sd2246264 * COEF_SCALE - G_FZ_H) / G_FZ),
         24'((-64'sd83756   * COEF_SCALE - G_FZ_H) / G_FZ) },
      '{ 24'(( 64'sd86343   * COEF_SCALE + G_TXY_H) / G_TXY),
         24'(( 64'sd62380   * COEF_SCALE + G_TXY_H) / G_TXY),
         24'((-64'sd3757811 * COEF_SCALE - G_TXY_H) / G_TXY),
         24'((-64'sd173684  * COEF_SCALE - G_TXY_H) / G_TXY),
         24'(( 64'sd3928231 * COEF_SCALE + G_TXY_H) / G_TXY),
         24'(( 64'sd142668  * COEF_SCALE + G_TXY_H) / G_TXY) },
      '{ 24'(( 64'sd4345049 * COEF_SCALE + G_TXY_H) / G_TXY),
         24'(( 64'sd61411   * COEF_SCALE + G_TXY_H) / G_TXY),
         24'((-64'sd2170741 * COEF_SCALE - G_TXY_H) / G_TXY),
         24'((-64'sd41397   * COEF_SCALE - G_TXY_H) / G_TXY),
         24'((-64'sd2331255 * COEF_SCALE - G_TXY_H) / G_TXY),
         24'((-64'sd147309  * COEF_SCALE - G_TXY_H) / G_TXY) },
      '{ 24'(( 64'sd44082   * COEF_SCALE + G_TZ_H) / G_TZ),
         24'((-64'sd2253919 * COEF_SCALE - G_TZ_H) / G_TZ),
         24'(( 64'sd148699  * COEF_SCALE + G_TZ_H) / G_TZ),
         24'((-64'sd2163087 * COEF_SCALE - G_TZ_H) / G_TZ),
         24'(( 64'sd143589  * COEF_SCALE + G_TZ_H) / G_TZ),
         24'((-64'sd2234803 * COEF_SCALE - G_TZ_H) / G_TZ) }
   };

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (x < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ===== design/ftcal_front.sv =====
// front end: accepts gauge frames, converts counts to volts, tags tare frames
module ftcal_front
   import ftcal_pkg::*;
#(
   parameter int ADC_BITS     = ADC_BITS_DEF,
   parameter int TARE_SAMPLES = TARE_SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [NUM_AXES*GAUGE_W-1:0]   in_data,
   input  logic signed [VAZ_W-1:0]       volt_at_zero,
   input  logic [VPC_W-1:0]              volt_per_count,
   input  logic                          q_full,
   output logic                          q_push,
   output frame_entry_type               q_entry
);

   localparam int TCW    = $clog2(TARE_SAMPLES + 1);
   localparam int CMP_W  = (ADC_BITS > GAUGE_W) ? ADC_BITS : GAUGE_W;
   localparam int PROD_W = GAUGE_W + VPC_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic [CMP_W-1:0] TOP_COUNT = CMP_W'((64'd1 << ADC_BITS) - 64'd2);

   typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} front_state_type;

   front_state_type             state_ff, state_in;
   logic [NUM_AXES*GAUGE_W-1:0] frame_ff, frame_in;
   logic [AXIS_W-1:0]           idx_ff, idx_in;
   logic                        pvld_ff, pvld_in;
   logic [AXIS_W-1:0]           pidx_ff, pidx_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   volt_vec_type                volt_ff, volt_in;
   logic [TCW-1:0]              tare_cnt_ff, tare_cnt_in;

   logic [GAUGE_W-1:0]          cnt_raw;
   logic [GAUGE_W-1:0]          cnt_clamped;
   logic signed [SUM_W-1:0]     volt_sum;

   always_comb begin
      cnt_raw = frame_ff[idx_ff*GAUGE_W +: GAUGE_W];
      if (cnt_raw == '0) begin
         cnt_clamped = GAUGE_W'(1);
      end else if (CMP_W'(cnt_raw) > TOP_COUNT) begin
         cnt_clamped = GAUGE_W'(TOP_COUNT);
      end else begin
         cnt_clamped = cnt_raw;
      end
      volt_sum = $signed({1'b0, prod_ff}) + SUM_W'(volt_at_zero);
   end

   always_comb begin
      state_in    = state_ff;
      frame_in    = frame_ff;
      idx_in      = idx_ff;
      pvld_in     = 1'b0;
      pidx_in     = idx_ff;
      prod_in     = PROD_W'(cnt_clamped) * PROD_W'(volt_per_count);
      volt_in     = volt_ff;
      tare_cnt_in = tare_cnt_ff;
      in_ready    = 1'b0;
      q_push      = 1'b0;

      if (pvld_ff) begin
         volt_in[pidx_ff] = sat32(64'(volt_sum));
      end

      unique case (state_ff)
         F_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               frame_in = in_data;
               idx_in   = '0;
               state_in = F_CONV;
            end
         end
         F_CONV: begin
            pvld_in = 1'b1;
            if (idx_ff == AXIS_W'(NUM_AXES - 1)) begin
               state_in = F_PUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         F_PUSH: begin
            // last voltage lands the cycle after the last product
            if (!pvld_ff && !q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
               if (tare_cnt_ff < TCW'(TARE_SAMPLES)) begin
                  tare_cnt_in = tare_cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign q_entry.volt    = volt_ff;
   assign q_entry.is_tare = (tare_cnt_ff < TCW'(TARE_SAMPLES));
   assign q_entry.is_last = (tare_cnt_ff == TCW'(TARE_SAMPLES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         pvld_ff     <= 1'b0;
         tare_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         pvld_ff     <= pvld_in;
         tare_cnt_ff <= tare_cnt_in;
      end
      frame_ff <= frame_in;
      idx_ff   <= idx_in;
      pidx_ff  <= pidx_in;
      prod_ff  <= prod_in;
      volt_ff  <= volt_in;
   end

endmodule

// ===== design/ftcal_fifo.sv =====
// short frame queue between the front and back ends
module ftcal_fifo
   import ftcal_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  frame_entry_type push_entry,
   input  logic            pop,
   output frame_entry_type head,
   output logic            full,
   output logic            empty
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   frame_entry_type   mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("frame pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("frame popped from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

// ===== design/ftcal_back.sv =====
// back end: matrix rows through six multiplier lanes, tare averaging and subtraction
module ftcal_back
   import ftcal_pkg::*;
#(
   parameter int TARE_SAMPLES = TARE_SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  frame_entry_type               q_head,
   input  logic                          q_empty,
   output logic                          q_pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [NUM_AXES*FORCE_W-1:0]   out_data
);

   localparam int MUL_W    = COEF_W + VOLT_W;
   localparam int PAIR_W   = MUL_W + 1;
   localparam int ACC_W    = MUL_W + 3;
   localparam int NPAIR    = NUM_AXES / 2;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd1 << (FRAC_SHIFT - 1));

   // tare sums stay below 2^35 in magnitude, so a rounded-up reciprocal
   // with a shift of 35 plus the ceiling of log2 of the divisor gives the exact quotient
   localparam int MAG_W    = TARE_SUM_W - 1;
   localparam int RCP_W    = MAG_W + 1;
   localparam int RCP_LO_W = RCP_W / 2;
   localparam int RCP_HI_W = RCP_W - RCP_LO_W;
   localparam int RCP_SH   = MAG_W + $clog2(TARE_SAMPLES);
   localparam int PART_W   = MAG_W + RCP_HI_W;
   localparam int WIDE_W   = MAG_W + RCP_W;
   localparam longint RCP_VAL = ((64'sd1 <<< RCP_SH) + 64'(TARE_SAMPLES) - 64'sd1)
                                / 64'(TARE_SAMPLES);
   localparam logic [RCP_W-1:0]    RCP    = RCP_W'(RCP_VAL);
   localparam logic [RCP_LO_W-1:0] RCP_LO = RCP[RCP_LO_W-1:0];
   localparam logic [RCP_HI_W-1:0] RCP_HI = RCP[RCP_W-1:RCP_LO_W];

   typedef enum logic [2:0] {B_IDLE, B_RUN, B_DRAIN, B_DIV, B_EMIT} back_state_type;

   back_state_type              state_ff, state_in;
   logic [AXIS_W-1:0]           row_ff, row_in;
   logic                        tare_ff, tare_in;
   logic                        last_ff, last_in;

   logic                        p_vld_ff, p_vld_in;
   logic [AXIS_W-1:0]           p_row_ff, p_row_in;
   logic signed [MUL_W-1:0]     prod_ff [NUM_AXES];
   logic signed [MUL_W-1:0]     prod_in [NUM_AXES];

   logic                        s1_vld_ff, s1_vld_in;
   logic [AXIS_W-1:0]           s1_row_ff, s1_row_in;
   logic signed [PAIR_W-1:0]    pair_ff [NPAIR];
   logic signed [PAIR_W-1:0]    pair_in [NPAIR];

   logic                        s2_vld_ff, s2_vld_in;
   logic [AXIS_W-1:0]           s2_row_ff, s2_row_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;

   logic                        r_vld_ff, r_vld_in;
   logic [AXIS_W-1:0]           r_row_ff, r_row_in;
   logic signed [FORCE_W-1:0]   force_ff, force_in;

   logic signed [TARE_SUM_W-1:0] tare_sum_ff [NUM_AXES];
   logic signed [TARE_SUM_W-1:0] tare_sum_in [NUM_AXES];
   logic signed [FORCE_W-1:0]    tare_val_ff [NUM_AXES];
   logic signed [FORCE_W-1:0]    tare_val_in [NUM_AXES];
   logic signed [FORCE_W-1:0]    res_ff [NUM_AXES];
   logic signed [FORCE_W-1:0]    res_in [NUM_AXES];

   logic                        div_ph_ff, div_ph_in;
   logic [MAG_W-1:0]            div_mag_ff [NUM_AXES];
   logic [MAG_W-1:0]            div_mag_in [NUM_AXES];
   logic [WIDE_W-1:0]           div_acc_ff [NUM_AXES];
   logic [WIDE_W-1:0]           div_acc_in [NUM_AXES];
   logic                        div_neg_ff [NUM_AXES];
   logic                        div_neg_in [NUM_AXES];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [NUM_AXES*FORCE_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [ACC_W-1:0]     acc_rnd;
   logic signed [ACC_W-1:0]     acc_shift;
   logic signed [FORCE_W:0]     diff;
   logic [PART_W-1:0]           div_part [NUM_AXES];
   logic [WIDE_W-1:0]           div_full [NUM_AXES];

   always_comb begin
      acc_rnd   = acc_ff + ROUND_BIAS;
      acc_shift = acc_rnd >>> FRAC_SHIFT;
      force_in  = sat32(64'(acc_shift));
      diff      = (FORCE_W + 1)'(force_ff) - (FORCE_W + 1)'(tare_val_ff[r_row_ff]);
      // low half of the reciprocal first, then the high half, selected by div_ph_ff
      for (int k = 0; k < NUM_AXES; k++) begin
         div_part[k] = PART_W'(div_mag_ff[k]) * PART_W'(div_ph_ff ? RCP_HI : RCP_LO);
         div_full[k] = div_acc_ff[k] + (WIDE_W'(div_part[k]) << RCP_LO_W);
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      tare_in      = tare_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      p_vld_in     = 1'b0;
      p_row_in     = row_ff;
      s1_vld_in    = p_vld_ff;
      s1_row_in    = p_row_ff;
      s2_vld_in    = s1_vld_ff;
      s2_row_in    = s1_row_ff;
      r_vld_in     = s2_vld_ff;
      r_row_in     = s2_row_ff;
      acc_in       = ACC_W'(pair_ff[0]);
      div_ph_in    = div_ph_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_data_in  = rsp_data_ff;

      for (int k = 1; k < NPAIR; k++) begin
         acc_in = acc_in + ACC_W'(pair_ff[k]);
      end
      for (int k = 0; k < NPAIR; k++) begin
         pair_in[k] = PAIR_W'(prod_ff[2*k]) + PAIR_W'(prod_ff[2*k+1]);
      end
      for (int k = 0; k < NUM_AXES; k++) begin
         prod_in[k]     = MUL_W'(COEF_ROM[row_ff][k]) * MUL_W'($signed(q_head.volt[k]));
         tare_sum_in[k] = tare_sum_ff[k];
         tare_val_in[k] = tare_val_ff[k];
         res_in[k]      = res_ff[k];
         div_mag_in[k]  = div_mag_ff[k];
         div_acc_in[k]  = div_acc_ff[k];
         div_neg_in[k]  = div_neg_ff[k];
      end

      // last pipe stage: accumulate tare or subtract it
      if (r_vld_ff) begin
         if (tare_ff) begin
            tare_sum_in[r_row_ff] = tare_sum_ff[r_row_ff] + TARE_SUM_W'(force_ff);
         end else begin
            res_in[r_row_ff] = sat32(64'(diff));
         end
      end

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               tare_in  = q_head.is_tare;
               last_in  = q_head.is_last;
               row_in   = '0;
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            p_vld_in = 1'b1;
            if (row_ff == AXIS_W'(NUM_AXES - 1)) begin
               q_pop    = 1'b1;
               state_in = B_DRAIN;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         B_DRAIN: begin
            if (r_vld_ff && r_row_ff == AXIS_W'(NUM_AXES - 1)) begin
               if (!tare_ff) begin
                  state_in = B_EMIT;
               end else if (last_ff) begin
                  // split each sum into sign and magnitude for the reciprocal divide
                  for (int k = 0; k < NUM_AXES; k++) begin
                     div_neg_in[k] = tare_sum_in[k][TARE_SUM_W-1];
                     div_mag_in[k] = div_neg_in[k] ? MAG_W'(-tare_sum_in[k])
                                                   : MAG_W'(tare_sum_in[k]);
                  end
                  div_ph_in = 1'b0;
                  state_in  = B_DIV;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         B_DIV: begin
            if (!div_ph_ff) begin
               for (int k = 0; k < NUM_AXES; k++) begin
                  div_acc_in[k] = WIDE_W'(div_part[k]);
               end
               div_ph_in = 1'b1;
            end else begin
               for (int k = 0; k < NUM_AXES; k++) begin
                  tare_val_in[k] = div_neg_ff[k] ? -div_full[k][RCP_SH +: FORCE_W]
                                                 : div_full[k][RCP_SH +: FORCE_W];
               end
               state_in = B_IDLE;
            end
         end
         B_EMIT: begin
            if (!rsp_valid_ff || out_ready) begin
               rsp_valid_in = 1'b1;
               for (int k = 0; k < NUM_AXES; k++) begin
                  rsp_data_in[k*FORCE_W +: FORCE_W] = res_ff[k];
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         p_vld_ff     <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         r_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_AXES; k++) begin
            tare_sum_ff[k] <= '0;
            tare_val_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         p_vld_ff     <= p_vld_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         r_vld_ff     <= r_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < NUM_AXES; k++) begin
            tare_sum_ff[k] <= tare_sum_in[k];
            tare_val_ff[k] <= tare_val_in[k];
         end
      end
      row_ff      <= row_in;
      tare_ff     <= tare_in;
      last_ff     <= last_in;
      p_row_ff    <= p_row_in;
      s1_row_ff   <= s1_row_in;
      s2_row_ff   <= s2_row_in;
      r_row_ff    <= r_row_in;
      acc_ff      <= acc_in;
      force_ff    <= force_in;
      div_ph_ff   <= div_ph_in;
      rsp_data_ff <= rsp_data_in;
      for (int k = 0; k < NUM_AXES; k++) begin
         prod_ff[k]    <= prod_in[k];
         res_ff[k]     <= res_in[k];
         div_mag_ff[k] <= div_mag_in[k];
         div_acc_ff[k] <= div_acc_in[k];
         div_neg_ff[k] <= div_neg_in[k];
      end
      for (int k = 0; k < NPAIR; k++) begin
         pair_ff[k] <= pair_in[k];
      end
   end

`ifndef NO_ASSERTIONS
   a_load_in_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_EMIT))
      else $error("result loaded outside emit state");
`endif

endmodule

// ===== design/six_axis_force_calibration_core.sv =====
// six-axis force/torque calibration core, top level
// Each beat on req carries six raw strain-gauge counts. The front end clamps
// each count away from zero and full scale and converts it to a voltage, one
// channel per cycle through a single multiplier. Converted frames wait in a
// two-entry queue. The back end runs one matrix row per cycle through six
// multiplier lanes and an add and round pipeline, and takes no new frame
// until the last one is done, which sets the sustained rate. The first
// TARE_SAMPLES frames after reset produce no rsp beat; their forces are
// summed, and after the last of them a reciprocal multiply, low half then
// high half, forms the tare that is subtracted from every later frame.
// Write csr only while the core is idle.
module six_axis_force_calibration_core
   import ftcal_pkg::*;
#(
   parameter int ADC_BITS     = ADC_BITS_DEF,
   parameter int TARE_SAMPLES = TARE_SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // gauge_0, gauge_1, gauge_2, gauge_3, gauge_4, gauge_5
   input  logic [NUM_AXES*GAUGE_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // force_x, force_y, force_z, torque_x, torque_y, torque_z
   output logic [NUM_AXES*FORCE_W-1:0]   rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   logic signed [VAZ_W-1:0] vaz_ff, vaz_in;
   logic [VPC_W-1:0]        vpc_ff, vpc_in;
   frame_entry_type         push_entry;
   frame_entry_type         head_entry;
   logic                    q_push;
   logic                    q_pop;
   logic                    q_full;
   logic                    q_empty;

   always_comb begin
      vaz_in = vaz_ff;
      vpc_in = vpc_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VOLT_AT_ZERO:   vaz_in = $signed(csr_wdata[VAZ_W-1:0]);
            CSR_VOLT_PER_COUNT: vpc_in = csr_wdata[VPC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vaz_ff <= VAZ_RESET;
         vpc_ff <= VPC_RESET;
      end else begin
         vaz_ff <= vaz_in;
         vpc_ff <= vpc_in;
      end
   end

   ftcal_front #(
      .ADC_BITS     (ADC_BITS),
      .TARE_SAMPLES (TARE_SAMPLES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_data        (req_tdata),
      .volt_at_zero   (vaz_ff),
      .volt_per_count (vpc_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   ftcal_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   ftcal_back #(
      .TARE_SAMPLES (TARE_SAMPLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (head_entry),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule
